// ----- src/ctdm_pkg.sv -----
// Shared types, constants and register codes for the cadence to duty mapper.
package ctdm_pkg;

	localparam int TIME_BITS_DEFAULT = 16;
	localparam int CAD_W = 16;
	localparam int DUTY_W = 16;
	localparam int MAG_W = 7;
	localparam int SWITCH_W = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int DIV_NUM_W = 32;
	localparam int DIV_CNT_W = 6;
	localparam int CAD_SCALE = 60000;
	localparam int CAD_FRAC = 16;
	localparam int CAD_DIVIDEND = CAD_SCALE * CAD_FRAC;
	localparam int CAD_DIVIDEND_W = 20;
	localparam logic [DIV_CNT_W-1:0] CAD_DIV_STEPS = DIV_CNT_W'(CAD_DIVIDEND_W);
	localparam logic [DIV_CNT_W-1:0] INTERP_DIV_STEPS = DIV_CNT_W'(16);
	localparam logic [DIV_NUM_W-1:0] CAD_NUM =
		DIV_NUM_W'(CAD_DIVIDEND) << (DIV_NUM_W - CAD_DIVIDEND_W);

	localparam logic [SWITCH_W-1:0] SW_OFF = 2'd0;
	localparam logic [SWITCH_W-1:0] SW_MID = 2'd1;
	localparam logic [SWITCH_W-1:0] SW_FULL = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_CAD_FLOOR = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CAD_CEIL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MID = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGNET_COUNT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SEND_PERIOD = 3'd6;

	localparam logic [CAD_W-1:0] RST_CAD_FLOOR = 16'd320;
	localparam logic [CAD_W-1:0] RST_CAD_CEIL = 16'd1280;
	localparam logic [DUTY_W-1:0] RST_DUTY_MIN = 16'd3277;
	localparam logic [DUTY_W-1:0] RST_DUTY_MID = 16'd16384;
	localparam logic [DUTY_W-1:0] RST_DUTY_MAX = 16'd32768;
	localparam logic [MAG_W-1:0] RST_MAGNET_COUNT = 7'd12;
	localparam logic [15:0] RST_SEND_PERIOD = 16'd50;

	typedef struct packed {
		logic [CAD_W-1:0] cad_floor;
		logic [CAD_W-1:0] cad_ceil;
		logic [DUTY_W-1:0] duty_min;
		logic [DUTY_W-1:0] duty_mid;
		logic [DUTY_W-1:0] duty_max;
		logic [MAG_W-1:0] magnet_count;
		logic [15:0] send_period;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [DIV_CNT_W-1:0] count;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_CAD,
		B_CWAIT,
		B_EVAL,
		B_MUL2,
		B_IDIV,
		B_IWAIT,
		B_DONE
	} back_state_t;

endpackage

// ----- src/ctdm_front.sv -----
// Front end: ages edge and send timers per tick and emits one job per tick.
module ctdm_front #(
	parameter int TIME_BITS = ctdm_pkg::TIME_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic pas_edge,
	input  logic [ctdm_pkg::SWITCH_W-1:0] switch_pos,
	input  logic [15:0] send_period,
	output logic [TIME_BITS-1:0] job_interval,
	output logic [ctdm_pkg::SWITCH_W-1:0] job_switch,
	output logic job_strobe
);

	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam logic [TIME_BITS-1:0] AGE_MAX = '1;

	logic [TIME_BITS-1:0] edge_age_q;
	logic [TIME_BITS-1:0] interval_q;
	logic [TIME_BITS-1:0] send_age_q;
	logic [TIME_BITS-1:0] age_inc;
	logic [TIME_BITS-1:0] age_edge;
	logic [TIME_BITS-1:0] interval_edge;
	logic [TIME_BITS-1:0] interval_next;
	logic [TIME_BITS-1:0] send_inc;
	logic [TIME_BITS-1:0] send_next;
	logic strobe;

	always_comb begin
		age_inc = (edge_age_q == AGE_MAX) ? AGE_MAX : edge_age_q + TIME_BITS'(1);
		age_edge = pas_edge ? '0 : age_inc;
		interval_edge = pas_edge ? age_inc : interval_q;
		// stale age stretches the interval so cadence decays
		interval_next = (age_edge > interval_edge) ? age_edge : interval_edge;
		send_inc = (send_age_q == AGE_MAX) ? AGE_MAX : send_age_q + TIME_BITS'(1);
		strobe = CMP_W'(send_inc) > CMP_W'(send_period);
		send_next = strobe ? '0 : send_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_age_q <= AGE_MAX;
			interval_q <= '0;
			send_age_q <= '0;
		end else if (accept) begin
			edge_age_q <= age_edge;
			interval_q <= interval_next;
			send_age_q <= send_next;
		end
	end

	assign job_interval = interval_next;
	assign job_switch = switch_pos;
	assign job_strobe = strobe;

endmodule

// ----- src/ctdm_queue.sv -----
// Short job queue between the front and back ends.
module ctdm_queue #(
	parameter int WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wr_data,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);

	localparam int DEPTH = ctdm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- src/ctdm_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by both divisions.
module ctdm_divider #(
	parameter int DEN_W = 23
) (
	input  logic clk,
	input  logic arst_n,
	input  ctdm_pkg::div_ctl_t ctl,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [ctdm_pkg::DIV_NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output ctdm_pkg::div_stat_t stat,
	output logic [ctdm_pkg::DIV_NUM_W-1:0] quo
);

	localparam int NW = ctdm_pkg::DIV_NUM_W;
	localparam int CW = ctdm_pkg::DIV_CNT_W;

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic fits;
	logic [DEN_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff = trial - {1'b0, den_q};
		fits = trial >= {1'b0, den_q};
		rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			den_q <= den;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = quo_q;

endmodule

// ----- src/ctdm_back.sv -----
// Back end: cadence division, duty interpolation and the result register.
module ctdm_back #(
	parameter int TIME_BITS = ctdm_pkg::TIME_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  ctdm_pkg::cfg_t cfg,
	input  logic q_empty,
	input  logic [TIME_BITS-1:0] q_interval,
	input  logic [ctdm_pkg::SWITCH_W-1:0] q_switch,
	input  logic q_strobe,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output logic [ctdm_pkg::DUTY_W-1:0] duty,
	output logic [ctdm_pkg::CAD_W-1:0] cadence,
	output logic send_strobe,
	output logic command_kind
);

	localparam int PROD_W = TIME_BITS + ctdm_pkg::MAG_W;
	localparam int DEN_W = (PROD_W > ctdm_pkg::CAD_W) ? PROD_W : ctdm_pkg::CAD_W;
	localparam int NW = ctdm_pkg::DIV_NUM_W;
	localparam int DW = ctdm_pkg::DUTY_W;
	localparam int CADW = ctdm_pkg::CAD_W;

	ctdm_pkg::back_state_t state_q;
	ctdm_pkg::back_state_t state_d;

	logic [TIME_BITS-1:0] job_interval_q;
	logic [ctdm_pkg::SWITCH_W-1:0] job_switch_q;
	logic job_strobe_q;
	logic [DEN_W-1:0] mul_q;
	logic [CADW-1:0] cad_q;
	logic [CADW-1:0] cdiff_q;
	logic [DW-1:0] tmag_q;
	logic tneg_q;
	logic [CADW-1:0] span_q;
	logic [NW-1:0] prod_q;
	logic [DW-1:0] duty_work_q;

	logic res_valid_q;
	logic [DW-1:0] res_duty_q;
	logic [CADW-1:0] res_cad_q;
	logic res_strobe_q;
	logic res_kind_q;

	ctdm_pkg::div_ctl_t div_ctl;
	ctdm_pkg::div_stat_t div_stat;
	logic [DEN_W-1:0] div_rem_init;
	logic [NW-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NW-1:0] div_quo;

	logic sw_on;
	logic [DW-1:0] target;
	logic cad_above;
	logic cad_below;
	logic span_zero;
	logic [DW+1:0] interp_sum;
	logic [DW-1:0] interp_duty;
	logic out_free;
	logic load_job;
	logic load_result;

	always_comb begin
		sw_on = (job_switch_q == ctdm_pkg::SW_MID) || (job_switch_q == ctdm_pkg::SW_FULL);
		target = (job_switch_q == ctdm_pkg::SW_FULL) ? cfg.duty_max : cfg.duty_mid;
		cad_above = cad_q > cfg.cad_ceil;
		cad_below = cad_q < cfg.cad_floor;
		span_zero = cfg.cad_ceil == cfg.cad_floor;
		interp_sum = tneg_q ? {2'b00, cfg.duty_min} - {2'b00, div_quo[DW-1:0]}
			: {2'b00, cfg.duty_min} + {2'b00, div_quo[DW-1:0]};
		// clamp to 0..65535
		if (interp_sum[DW+1]) begin
			interp_duty = '0;
		end else if (interp_sum[DW]) begin
			interp_duty = '1;
		end else begin
			interp_duty = interp_sum[DW-1:0];
		end
		out_free = !res_valid_q || pop;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctdm_pkg::B_IDLE: begin
				if (!q_empty) state_d = ctdm_pkg::B_MUL;
			end
			ctdm_pkg::B_MUL: state_d = ctdm_pkg::B_CAD;
			ctdm_pkg::B_CAD: begin
				state_d = (mul_q == '0) ? ctdm_pkg::B_EVAL : ctdm_pkg::B_CWAIT;
			end
			ctdm_pkg::B_CWAIT: begin
				if (div_stat.done) state_d = ctdm_pkg::B_EVAL;
			end
			ctdm_pkg::B_EVAL: begin
				priority if (!sw_on || cad_above || cad_below || span_zero) begin
					state_d = ctdm_pkg::B_DONE;
				end else begin
					state_d = ctdm_pkg::B_MUL2;
				end
			end
			ctdm_pkg::B_MUL2: state_d = ctdm_pkg::B_IDIV;
			ctdm_pkg::B_IDIV: state_d = ctdm_pkg::B_IWAIT;
			ctdm_pkg::B_IWAIT: begin
				if (div_stat.done) state_d = ctdm_pkg::B_DONE;
			end
			ctdm_pkg::B_DONE: begin
				if (out_free) state_d = ctdm_pkg::B_IDLE;
			end
			default: state_d = ctdm_pkg::B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		load_job = 1'b0;
		load_result = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.count = ctdm_pkg::CAD_DIV_STEPS;
		div_rem_init = '0;
		div_num = ctdm_pkg::CAD_NUM;
		div_den = mul_q;
		unique case (state_q)
			ctdm_pkg::B_IDLE: load_job = !q_empty;
			ctdm_pkg::B_CAD: div_ctl.start = (mul_q != '0);
			ctdm_pkg::B_IDIV: begin
				div_ctl.start = 1'b1;
				div_ctl.count = ctdm_pkg::INTERP_DIV_STEPS;
				div_rem_init = DEN_W'(prod_q[NW-1:NW/2]);
				div_num = {prod_q[NW/2-1:0], {(NW/2){1'b0}}};
				div_den = DEN_W'(span_q);
			end
			ctdm_pkg::B_DONE: load_result = out_free;
			default: begin
			end
		endcase
	end

	assign q_pop = load_job;

	ctdm_divider #(
		.DEN_W(DEN_W)
	) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.rem_init(div_rem_init),
		.num(div_num),
		.den(div_den),
		.stat(div_stat),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctdm_pkg::B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_result) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			job_interval_q <= q_interval;
			job_switch_q <= q_switch;
			job_strobe_q <= q_strobe;
		end
		if (state_q == ctdm_pkg::B_MUL) begin
			mul_q <= DEN_W'(PROD_W'(job_interval_q) * PROD_W'(cfg.magnet_count));
		end
		if (state_q == ctdm_pkg::B_CAD && mul_q == '0) begin
			cad_q <= '0;
		end
		if (state_q == ctdm_pkg::B_CWAIT && div_stat.done) begin
			// saturate the quotient to the cadence width
			cad_q <= (|div_quo[NW-1:CADW]) ? '1 : div_quo[CADW-1:0];
		end
		if (state_q == ctdm_pkg::B_EVAL) begin
			// above the ceiling wins over below the floor when the limits cross
			priority if (!sw_on) begin
				duty_work_q <= '0;
			end else if (cad_above) begin
				duty_work_q <= target;
			end else if (cad_below) begin
				duty_work_q <= '0;
			end else begin
				duty_work_q <= cfg.duty_min;
			end
			cdiff_q <= cad_q - cfg.cad_floor;
			span_q <= cfg.cad_ceil - cfg.cad_floor;
			tneg_q <= target < cfg.duty_min;
			tmag_q <= (target < cfg.duty_min) ? cfg.duty_min - target
				: target - cfg.duty_min;
		end
		if (state_q == ctdm_pkg::B_MUL2) begin
			prod_q <= NW'(cdiff_q) * NW'(tmag_q);
		end
		if (state_q == ctdm_pkg::B_IWAIT && div_stat.done) begin
			duty_work_q <= interp_duty;
		end
		if (load_result) begin
			res_duty_q <= duty_work_q;
			res_cad_q <= cad_q;
			res_strobe_q <= job_strobe_q;
			res_kind_q <= (duty_work_q != '0);
		end
	end

	assign empty = !res_valid_q;
	assign duty = res_duty_q;
	assign cadence = res_cad_q;
	assign send_strobe = res_strobe_q;
	assign command_kind = res_kind_q;

`ifndef SYNTH
	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ctdm_pkg::B_CWAIT || state_q == ctdm_pkg::B_IWAIT))
		else $error("divider busy outside a wait state");
	a_kind_matches_duty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_kind_q == (res_duty_q != '0)))
		else $error("command kind does not match duty");
	a_done_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctdm_pkg::B_DONE && !res_valid_q) |=> res_valid_q)
		else $error("finished job not moved to result register");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ctdm_pkg::B_IDLE && !q_empty))
		else $error("job taken while back end busy");
`endif

endmodule

// ----- src/cadence_to_throttle_duty_mapper.sv -----
// Top level: configuration registers, front end, job queue and back end.
// A job passes the queue and the back end states B_IDLE, B_MUL, B_CAD, B_CWAIT,
// B_EVAL, then B_MUL2, B_IDIV and B_IWAIT if it interpolates, and B_DONE.
// A zero interval or magnet count skips B_CWAIT. The back end takes a new job only
// once the last is in the result register; divider steps: 20 cadence, 16 interp.
// Reset (arst_n low, asynchronous): registers take defaults, edge age saturates,
// interval and send age clear, queue and result register empty.
module cadence_to_throttle_duty_mapper #(
	parameter int TIME_BITS = ctdm_pkg::TIME_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic pas_edge,
	input  logic [ctdm_pkg::SWITCH_W-1:0] switch_pos,
	output logic empty,
	input  logic pop,
	output logic [ctdm_pkg::DUTY_W-1:0] duty,
	output logic [ctdm_pkg::CAD_W-1:0] cadence,
	output logic send_strobe,
	output logic command_kind,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ctdm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ctdm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int JOB_W = TIME_BITS + ctdm_pkg::SWITCH_W + 1;

	ctdm_pkg::cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic accept;
	logic [TIME_BITS-1:0] job_interval;
	logic [ctdm_pkg::SWITCH_W-1:0] job_switch;
	logic job_strobe;
	logic [JOB_W-1:0] q_wr_data;
	logic [JOB_W-1:0] q_rd_data;

	assign cfg_ready = 1'b1;
	assign full = q_full;
	assign accept = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cad_floor <= ctdm_pkg::RST_CAD_FLOOR;
			cfg_q.cad_ceil <= ctdm_pkg::RST_CAD_CEIL;
			cfg_q.duty_min <= ctdm_pkg::RST_DUTY_MIN;
			cfg_q.duty_mid <= ctdm_pkg::RST_DUTY_MID;
			cfg_q.duty_max <= ctdm_pkg::RST_DUTY_MAX;
			cfg_q.magnet_count <= ctdm_pkg::RST_MAGNET_COUNT;
			cfg_q.send_period <= ctdm_pkg::RST_SEND_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ctdm_pkg::REG_CAD_FLOOR: cfg_q.cad_floor <= cfg_data;
				ctdm_pkg::REG_CAD_CEIL: cfg_q.cad_ceil <= cfg_data;
				ctdm_pkg::REG_DUTY_MIN: cfg_q.duty_min <= cfg_data;
				ctdm_pkg::REG_DUTY_MID: cfg_q.duty_mid <= cfg_data;
				ctdm_pkg::REG_DUTY_MAX: cfg_q.duty_max <= cfg_data;
				ctdm_pkg::REG_MAGNET_COUNT: cfg_q.magnet_count <= cfg_data[ctdm_pkg::MAG_W-1:0];
				ctdm_pkg::REG_SEND_PERIOD: cfg_q.send_period <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ctdm_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.pas_edge(pas_edge),
		.switch_pos(switch_pos),
		.send_period(cfg_q.send_period),
		.job_interval(job_interval),
		.job_switch(job_switch),
		.job_strobe(job_strobe)
	);

	assign q_wr_data = {job_interval, job_switch, job_strobe};

	ctdm_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(q_wr_data),
		.full(q_full),
		.pop(q_pop),
		.rd_data(q_rd_data),
		.empty(q_empty)
	);

	ctdm_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_interval(q_rd_data[JOB_W-1 -: TIME_BITS]),
		.q_switch(q_rd_data[ctdm_pkg::SWITCH_W:1]),
		.q_strobe(q_rd_data[0]),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.duty(duty),
		.cadence(cadence),
		.send_strobe(send_strobe),
		.command_kind(command_kind)
	);

endmodule
